FILE: src/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// Types, item kinds and MAC classification helpers for the peer MAC table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    // item kinds
    localparam logic [1:0] KIND_SET_PRIMARY    = 2'd0;
    localparam logic [1:0] KIND_LEARN_BRIDGED  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP_PRIMARY = 2'd2;
    localparam logic [1:0] KIND_LOOKUP_BRIDGED = 2'd3;

    // learn status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // peer field width and MAC prefix bytes
    localparam int unsigned PEER_ID_W = 5;
    localparam logic [7:0] MCAST_V4_B0 = 8'h01;
    localparam logic [7:0] MCAST_V4_B1 = 8'h00;
    localparam logic [7:0] MCAST_V4_B2 = 8'h5e;
    localparam logic [7:0] MCAST_V6_B  = 8'h33;

    typedef struct packed {
        logic [1:0]           kind;
        logic [PEER_ID_W-1:0] peer_id;
        logic [47:0]          mac_addr;
    } mpt_item_t;

    typedef struct packed {
        logic                 hit;
        logic [PEER_ID_W-1:0] found_peer;
        logic                 status;
        logic                 is_zero;
        logic                 is_broadcast;
        logic                 is_multicast;
        logic                 is_valid;
    } mpt_result_t;

    // one bridged table entry
    typedef struct packed {
        logic [47:0]          mac;
        logic [PEER_ID_W-1:0] owner;
    } mpt_bentry_t;

    function automatic logic mac_is_multicast(input logic [47:0] mac);
        logic v4;
        logic v6;
        v4 = (mac[47:40] == MCAST_V4_B0) && (mac[39:32] == MCAST_V4_B1)
            && (mac[31:24] == MCAST_V4_B2);
        v6 = (mac[47:40] == MCAST_V6_B) && (mac[39:32] == MCAST_V6_B);
        return v4 || v6;
    endfunction

endpackage

`default_nettype wire

FILE: src/mac_peer_table_core.sv
// ----------------------------------------------------------------------------
// mac_peer_table_core
// Peer MAC table: primary MAC per peer plus a shared learned bridged table.
// ----------------------------------------------------------------------------
// Set primary or out-of-range learn goes from accept straight to S_DONE.
// Lookup primary scans up to PEER_SLOTS primary entries (stops at first match);
// learn and lookup bridged scan up to N entries, N = filled bridged entries
// (at most BRIDGED_ENTRIES), one entry per cycle through the registered memory read.
// One item at a time; busy drops in the result strobe cycle, next item taken there.
// Reset clears valid bits and the bridged fill count at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mac_peer_table_core #(
    parameter int unsigned PEER_SLOTS      = 32,
    parameter int unsigned BRIDGED_ENTRIES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mpt_pkg::mpt_item_t  item,
    output logic                     done,
    output mpt_pkg::mpt_result_t     result
);
    import mpt_pkg::*;

    localparam int unsigned PW   = $clog2(PEER_SLOTS);
    localparam int unsigned BW   = $clog2(BRIDGED_ENTRIES);
    localparam int unsigned IDW  = (PW > PEER_ID_W) ? PW : PEER_ID_W;
    localparam int unsigned BCW  = $clog2(BRIDGED_ENTRIES + 1);
    localparam int unsigned PCW  = $clog2(PEER_SLOTS + 1);
    localparam int unsigned CW   = (PCW > BCW) ? PCW : BCW;
    localparam logic [IDW:0]   PEER_LIM = (IDW + 1)'(PEER_SLOTS);
    localparam logic [CW-1:0]  PEER_CNT = CW'(PEER_SLOTS);
    localparam logic [BCW-1:0] BR_FULL  = BCW'(BRIDGED_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PSCAN = 4'b0010,
        S_BSCAN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // control and payload registers
    state_t            state_reg, state_next;
    mpt_item_t         item_reg, item_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [IDW-1:0]    found_reg, found_next;
    logic              present_reg, present_next;
    logic [BCW-1:0]    count_reg, count_next;
    logic [PEER_SLOTS-1:0] pvalid_reg, pvalid_next;
    logic              done_reg, done_next;
    mpt_result_t       result_reg, result_next;

    // memories and their registered read data
    logic [47:0]       pmem [PEER_SLOTS];
    mpt_bentry_t       bmem [BRIDGED_ENTRIES];
    logic [47:0]       p_rdata_reg;
    mpt_bentry_t       b_rdata_reg;
    logic              pwr_en;
    logic              bwr_en;

    // derived values
    logic [IDW-1:0]    in_peer_w;
    logic              in_peer_ok;
    logic [IDW-1:0]    reg_peer_w;
    logic              reg_peer_ok;
    logic [IDW-1:0]    owner_w;
    logic              owner_ok;
    logic [CW-1:0]     limit;
    logic              issue;
    logic              p_match;
    logic              b_match;
    logic              l_match;
    logic              mac_zero;
    logic              mac_bcast;

    // peer range checks
    assign in_peer_w   = IDW'(item.peer_id);
    assign in_peer_ok  = {1'b0, in_peer_w} < PEER_LIM;
    assign reg_peer_w  = IDW'(item_reg.peer_id);
    assign reg_peer_ok = {1'b0, reg_peer_w} < PEER_LIM;
    assign owner_w     = IDW'(b_rdata_reg.owner);
    assign owner_ok    = {1'b0, owner_w} < PEER_LIM;

    // scan compare on data read in the previous cycle
    assign p_match = pvalid_reg[pend_idx_reg[PW-1:0]]
        && (p_rdata_reg == item_reg.mac_addr);
    assign b_match = owner_ok && pvalid_reg[owner_w[PW-1:0]]
        && (b_rdata_reg.mac == item_reg.mac_addr);
    assign l_match = (b_rdata_reg.owner == item_reg.peer_id)
        && (b_rdata_reg.mac == item_reg.mac_addr);

    // scan bound and read issue
    assign limit = (state_reg == S_PSCAN) ? PEER_CNT : CW'(count_reg);
    assign issue = idx_reg < limit;

    // MAC classification
    assign mac_zero  = (item_reg.mac_addr == '0);
    assign mac_bcast = (item_reg.mac_addr == '1);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = idx_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        present_next  = present_reg;
        count_next    = count_reg;
        pvalid_next   = pvalid_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        pwr_en        = 1'b0;
        bwr_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next    = item;
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    found_next   = '0;
                    present_next = 1'b0;
                    unique case (item.kind)
                        KIND_SET_PRIMARY:    state_next = S_DONE;
                        KIND_LEARN_BRIDGED:  state_next = in_peer_ok ? S_BSCAN : S_DONE;
                        KIND_LOOKUP_PRIMARY: state_next = S_PSCAN;
                        KIND_LOOKUP_BRIDGED: state_next = S_BSCAN;
                        default:             state_next = S_DONE;
                    endcase
                end
            end

            S_PSCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                if (pend_reg && p_match)
                begin
                    hit_next   = 1'b1;
                    found_next = IDW'(pend_idx_reg[PW-1:0]);
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!pend_reg && !issue)
                begin
                    state_next = S_DONE;
                end
            end

            S_BSCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                if (pend_reg && (item_reg.kind == KIND_LEARN_BRIDGED) && l_match)
                begin
                    // already held by this peer, stop early
                    present_next = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    // keep the lowest owning peer
                    if (pend_reg && (item_reg.kind == KIND_LOOKUP_BRIDGED) && b_match
                        && (!hit_reg || (owner_w < found_reg)))
                    begin
                        hit_next   = 1'b1;
                        found_next = owner_w;
                    end
                    if (!pend_reg && !issue)
                        state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                result_next.hit          = hit_reg;
                result_next.found_peer   = hit_reg ? found_reg[PEER_ID_W-1:0] : '0;
                result_next.status       = STATUS_OK;
                result_next.is_zero      = mac_zero;
                result_next.is_broadcast = mac_bcast;
                result_next.is_multicast = mac_is_multicast(item_reg.mac_addr);
                result_next.is_valid     = !mac_zero && !mac_bcast;

                case (item_reg.kind)
                    KIND_SET_PRIMARY:
                    begin
                        if (reg_peer_ok)
                        begin
                            pwr_en = 1'b1;
                            pvalid_next[reg_peer_w[PW-1:0]] = 1'b1;
                        end
                    end
                    KIND_LEARN_BRIDGED:
                    begin
                        if (reg_peer_ok && !present_reg)
                        begin
                            if (count_reg == BR_FULL)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                bwr_en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            present_reg <= 1'b0;
            count_reg   <= '0;
            pvalid_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            pvalid_reg  <= pvalid_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        result_reg   <= result_next;
    end

    // primary MAC memory
    always_ff @(posedge clk)
    begin
        if (pwr_en)
            pmem[reg_peer_w[PW-1:0]] <= item_reg.mac_addr;
        p_rdata_reg <= pmem[idx_reg[PW-1:0]];
    end

    // bridged MAC memory, filled in order from entry zero
    always_ff @(posedge clk)
    begin
        if (bwr_en)
            bmem[count_reg[BW-1:0]] <= '{mac: item_reg.mac_addr, owner: item_reg.peer_id};
        b_rdata_reg <= bmem[idx_reg[BW-1:0]];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: bench/mpt_checker.sv
// ----------------------------------------------------------------------------
// mpt_checker
// Watches the item and result channels of the peer MAC table, keeps its own
// copy of the primary and bridged tables, predicts each result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpt_checker #(
    parameter int unsigned PEER_SLOTS      = 32,
    parameter int unsigned BRIDGED_ENTRIES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire mpt_pkg::mpt_item_t    item,
    input  wire logic                  done,
    input  wire mpt_pkg::mpt_result_t  result,
    output int unsigned                fail_count,
    output int unsigned                pending,
    output int unsigned                checked,
    output int unsigned                lookup_hits,
    output int unsigned                full_learns
);
    import mpt_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // shadow copy of the table contents
    logic [47:0]          peer_mac     [PEER_SLOTS];
    bit                   peer_mac_ok  [PEER_SLOTS];
    logic [47:0]          learned_mac  [BRIDGED_ENTRIES];
    logic [PEER_ID_W-1:0] learned_peer [BRIDGED_ENTRIES];
    bit                   learned_used [BRIDGED_ENTRIES];

    mpt_result_t expected_results[$];
    mpt_result_t want;

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        checked     = 0;
        lookup_hits = 0;
        full_learns = 0;
    end

    // apply one item to the shadow tables and return the result it should give
    function automatic mpt_result_t apply_table_item(input mpt_item_t it);
        mpt_result_t r;
        bit          present;
        bit          have_free;
        int unsigned free_idx;
        int unsigned owner;
        r         = '0;
        present   = 1'b0;
        have_free = 1'b0;
        free_idx  = 0;
        case (it.kind)
            KIND_SET_PRIMARY:
            begin
                peer_mac[it.peer_id]    = it.mac_addr;
                peer_mac_ok[it.peer_id] = 1'b1;
            end
            KIND_LEARN_BRIDGED:
            begin
                for (int unsigned i = 0; i < BRIDGED_ENTRIES; i++)
                begin
                    if (learned_used[i])
                    begin
                        if (learned_peer[i] == it.peer_id && learned_mac[i] == it.mac_addr)
                            present = 1'b1;
                    end
                    else if (!have_free)
                    begin
                        have_free = 1'b1;
                        free_idx  = i;
                    end
                end
                if (!present)
                begin
                    if (have_free)
                    begin
                        learned_mac[free_idx]  = it.mac_addr;
                        learned_peer[free_idx] = it.peer_id;
                        learned_used[free_idx] = 1'b1;
                    end
                    else
                        r.status = STATUS_FULL;
                end
            end
            KIND_LOOKUP_PRIMARY:
            begin
                // lowest valid peer wins
                for (int unsigned p = 0; p < PEER_SLOTS; p++)
                begin
                    if (!r.hit && peer_mac_ok[p] && peer_mac[p] == it.mac_addr)
                    begin
                        r.hit        = 1'b1;
                        r.found_peer = PEER_ID_W'(p);
                    end
                end
            end
            default:
            begin
                // owner must have a valid primary; lowest owner wins
                for (int unsigned i = 0; i < BRIDGED_ENTRIES; i++)
                begin
                    owner = learned_peer[i];
                    if (learned_used[i] && peer_mac_ok[owner]
                        && learned_mac[i] == it.mac_addr
                        && (!r.hit || owner < r.found_peer))
                    begin
                        r.hit        = 1'b1;
                        r.found_peer = PEER_ID_W'(owner);
                    end
                end
            end
        endcase
        // address classification
        r.is_zero      = (it.mac_addr == 48'h0);
        r.is_broadcast = (it.mac_addr == {48{1'b1}});
        r.is_multicast = (it.mac_addr[47:24] == {MCAST_V4_B0, MCAST_V4_B1, MCAST_V4_B2})
                      || (it.mac_addr[47:32] == {MCAST_V6_B, MCAST_V6_B});
        r.is_valid     = !r.is_zero && !r.is_broadcast;
        return r;
    endfunction

    // compare finished results first, then record the newly accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int unsigned p = 0; p < PEER_SLOTS; p++)
                peer_mac_ok[p] = 1'b0;
            for (int unsigned i = 0; i < BRIDGED_ENTRIES; i++)
                learned_used[i] = 1'b0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("[%0t] result with no item outstanding: %p", $realtime,
                            result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.hit)
                        lookup_hits++;
                    if (want.status == STATUS_FULL)
                        full_learns++;
                    if (result.hit !== want.hit || result.found_peer !== want.found_peer
                        || result.status !== want.status || result.is_zero !== want.is_zero
                        || result.is_broadcast !== want.is_broadcast
                        || result.is_multicast !== want.is_multicast
                        || result.is_valid !== want.is_valid)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display("[%0t] result %0d mismatch", $realtime, checked);
                            $display({"    expected hit=%0b peer=%0d status=%0b",
                                " zero=%0b bcast=%0b mcast=%0b valid=%0b"},
                                want.hit, want.found_peer, want.status, want.is_zero,
                                want.is_broadcast, want.is_multicast, want.is_valid);
                            $display({"    actual   hit=%0b peer=%0d status=%0b",
                                " zero=%0b bcast=%0b mcast=%0b valid=%0b"},
                                result.hit, result.found_peer, result.status, result.is_zero,
                                result.is_broadcast, result.is_multicast, result.is_valid);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_table_item(item));
            pending = expected_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random table items into mac_peer_table_core with
// random gaps; the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import mpt_pkg::*;

    localparam int unsigned PEER_SLOTS      = 32;
    localparam int unsigned BRIDGED_ENTRIES = 64;
    localparam int unsigned RANDOM_ITEMS    = 1500;
    localparam int unsigned MAX_GAP         = 17;
    localparam int unsigned STALL_LIMIT     = 1000;
    localparam int unsigned DRAIN_CYCLES    = 100;
    localparam int unsigned POOL_SIZE       = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    mpt_item_t   item;
    logic        done;
    mpt_result_t result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned lookup_hits;
    int unsigned full_learns;

    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;
    bit          no_idle      = 1'b0;
    logic [47:0] mac_pool [POOL_SIZE];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    mac_peer_table_core #(
        .PEER_SLOTS      (PEER_SLOTS),
        .BRIDGED_ENTRIES (BRIDGED_ENTRIES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    mpt_checker #(
        .PEER_SLOTS      (PEER_SLOTS),
        .BRIDGED_ENTRIES (BRIDGED_ENTRIES)
    ) CHECK (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .lookup_hits (lookup_hits),
        .full_learns (full_learns)
    );

    // watchdog: ends the run after too long without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic mpt_item_t make_item(input logic [1:0] kind, input int unsigned peer,
                                            input logic [47:0] mac);
        mpt_item_t it;
        it.kind     = kind;
        it.peer_id  = PEER_ID_W'(peer);
        it.mac_addr = mac;
        return it;
    endfunction

    // mostly pooled addresses so that lookups hit, plus noise, multicast prefixes and prefix near misses
    function automatic logic [47:0] pick_mac();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (roll < 90)
            return 48'({$urandom(), $urandom()});
        case ($urandom_range(0, 2))
            0:       return {MCAST_V4_B0, MCAST_V4_B1, MCAST_V4_B2, 24'($urandom())};
            1:       return {MCAST_V6_B, MCAST_V6_B, 32'($urandom())};
            default: return {MCAST_V4_B0, MCAST_V4_B1, MCAST_V4_B2 + 8'd1, 24'($urandom())};
        endcase
    endfunction

    function automatic int unsigned pick_peer();
        if ($urandom_range(0, 99) < 60)
            return $urandom_range(0, 7);
        return $urandom_range(0, PEER_SLOTS - 1);
    endfunction

    // present one item after a random gap (none in back-to-back stretches) and wait until it is taken
    task automatic issue_item(input mpt_item_t it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        // switch between idling and back-to-back stretches now and then
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
    endtask

    initial
    begin
        int unsigned directed_count;
        int unsigned roll;
        int unsigned peer;
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [1:0]  kind;

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        for (int unsigned i = 0; i < 8; i++)
            mac_pool[i] = 48'({$urandom(), $urandom()});
        mac_pool[8]  = {MCAST_V4_B0, MCAST_V4_B1, MCAST_V4_B2, 24'h000001};
        mac_pool[9]  = {MCAST_V6_B, MCAST_V6_B, 32'h0000_00fb};
        mac_pool[10] = 48'h0;
        mac_pool[11] = {48{1'b1}};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, owner without primary, duplicates, lowest peer wins
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h0));
        issue_item(make_item(KIND_LOOKUP_BRIDGED, 0, {48{1'b1}}));
        issue_item(make_item(KIND_LEARN_BRIDGED, 3, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_LOOKUP_BRIDGED, 0, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_SET_PRIMARY, 31, {48{1'b1}}));
        issue_item(make_item(KIND_SET_PRIMARY, 0, 48'h0));
        issue_item(make_item(KIND_SET_PRIMARY, 3, 48'h0100_5e7f_ffff));
        issue_item(make_item(KIND_LOOKUP_BRIDGED, 7, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_LEARN_BRIDGED, 3, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_LEARN_BRIDGED, 31, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_LOOKUP_BRIDGED, 31, 48'h0200_0000_00aa));
        issue_item(make_item(KIND_SET_PRIMARY, 5, 48'h3333_0000_0001));
        issue_item(make_item(KIND_SET_PRIMARY, 20, 48'h3333_0000_0001));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h3333_0000_0001));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 31, {48{1'b1}}));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h0));
        issue_item(make_item(KIND_SET_PRIMARY, 5, 48'h0100_5f00_0000));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h3333_0000_0001));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h0100_5e7f_ffff));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 0, 48'h3334_0000_0001));
        issue_item(make_item(KIND_LEARN_BRIDGED, 0, 48'h0));
        issue_item(make_item(KIND_LOOKUP_BRIDGED, 0, 48'h0));
        issue_item(make_item(KIND_LOOKUP_PRIMARY, 31, 48'h0100_5e00_0000));
        directed_count = items_sent;

        // random: mix of set/learn/lookup chains and single items
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                peer  = pick_peer();
                mac_a = pick_mac();
                mac_b = pick_mac();
                issue_item(make_item(KIND_SET_PRIMARY, peer, mac_a));
                issue_item(make_item(KIND_LEARN_BRIDGED, peer, mac_b));
                issue_item(make_item(KIND_LOOKUP_BRIDGED, $urandom_range(0, PEER_SLOTS - 1), mac_b));
            end
            else
            begin
                if (roll < 25)
                    kind = KIND_SET_PRIMARY;
                else if (roll < 45)
                    kind = KIND_LEARN_BRIDGED;
                else if (roll < 70)
                    kind = KIND_LOOKUP_PRIMARY;
                else
                    kind = KIND_LOOKUP_BRIDGED;
                issue_item(make_item(kind, pick_peer(), pick_mac()));
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // drain outstanding results, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent (%0d directed), %0d results checked", items_sent,
            directed_count, checked);
        $display("%0d lookups found a peer, %0d learns refused on a full bridged table",
            lookup_hits, full_learns);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/mpt_pkg.sv
src/mac_peer_table_core.sv
bench/mpt_checker.sv
bench/testbench.sv
